>>> rtl/lpcv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpcv_pkg
// Shared types and codes for the LRU victim select block.
// ----------------------------------------------------------------------------
package lpcv_pkg;

	localparam int NUM_SETS_DEF = 256;
	localparam int NUM_WAYS_DEF = 8;
	localparam int TAG_BITS_DEF = 20;

	localparam logic [1:0] OP_TOUCH  = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_UPDATE = 2'd2;

	localparam logic [1:0] LS_CLEAN = 2'd1;
	localparam logic [1:0] LS_DIRTY = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  set_index;
		logic [2:0]  way_index;
		logic [19:0] tag;
		logic [1:0]  line_status;
	} in_item_t;

	typedef struct packed {
		logic [2:0] victim_way;
		logic       victim_clean;
	} out_item_t;

	// classified command handed from front to back
	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  way;
		logic [19:0] tag;
		logic [1:0]  status;
	} cmd_t;

endpackage
`default_nettype wire

>>> rtl/lru_prefer_clean_victim_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_prefer_clean_victim_select
// Timestamp LRU replacement with optional preference for clean lines.
// ----------------------------------------------------------------------------
// Items enter a two-entry command queue, up to one per cycle while not full.
// The back end handles each item in two states: idle pops it and reads the
// whole set (stamps, tags and status of every way) from the set memory, exec
// updates or searches it and writes it back. Items do not overlap. Victim
// results wait in a two-entry result queue. A per-set valid bit makes
// unwritten sets read as reset, so no clearing pass follows reset. Items with
// opcode 3, or updates to a way beyond the set, are dropped at the front.
// ----------------------------------------------------------------------------
module lru_prefer_clean_victim_select #(
	parameter int NUM_SETS = lpcv_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS = lpcv_pkg::NUM_WAYS_DEF,
	parameter int TAG_BITS = lpcv_pkg::TAG_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire lpcv_pkg::in_item_t   item,
	output logic                      full,
	output logic                      empty,
	input  wire logic                 pop,
	output lpcv_pkg::out_item_t       result,
	input  wire logic                 policy_we,
	input  wire logic                 policy_wdata
);
	import lpcv_pkg::*;

	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int RW    = $bits(out_item_t);

	logic             policy_q;
	cmd_t             cmd;
	logic [SET_W-1:0] cmd_set;
	logic             cmd_empty, cmd_pop;
	logic             res_full, res_push;
	out_item_t        res;
	logic [RW-1:0]    res_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b0;
		end else if (policy_we) begin
			policy_q <= policy_wdata;
		end
	end

	lpcv_front #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .SET_W(SET_W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cmd_set  (cmd_set),
		.cmd_empty(cmd_empty)
	);

	lpcv_back #(
		.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .TAG_BITS(TAG_BITS), .SET_W(SET_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.policy_mode(policy_q),
		.cmd_empty  (cmd_empty),
		.cmd        (cmd),
		.cmd_set    (cmd_set),
		.cmd_pop    (cmd_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res)
	);

	lpcv_fifo #(.W(RW), .DEPTH(2)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (res_push),
		.wdata (res),
		.full  (res_full),
		.rd    (pop),
		.rdata (res_bits),
		.empty (empty)
	);

	assign result = res_bits;

endmodule
`default_nettype wire

>>> rtl/lpcv_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpcv_fifo
// Small register queue, power-of-two depth.
// ----------------------------------------------------------------------------
module lpcv_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         rd,
	output logic [W-1:0]      rdata,
	output logic              empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wdata;
	end

endmodule
`default_nettype wire

>>> rtl/lpcv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpcv_front
// Accepts items, folds the set index, drops opcode-3 items and updates to a way beyond the set, queues commands.
// ----------------------------------------------------------------------------
module lpcv_front #(
	parameter int NUM_SETS = 256,
	parameter int NUM_WAYS = 8,
	parameter int SET_W    = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire lpcv_pkg::in_item_t  item,
	output logic                     full,
	input  wire logic                cmd_pop,
	output lpcv_pkg::cmd_t           cmd,
	output logic [SET_W-1:0]         cmd_set,
	output logic                     cmd_empty
);
	import lpcv_pkg::*;

	localparam int QW = $bits(cmd_t) + SET_W;

	logic [SET_W-1:0] mod_tbl [256];
	logic             keep;
	cmd_t             c;
	logic [QW-1:0]    q_out;

	for (genvar g = 0; g < 256; g++) begin : g_mod
		assign mod_tbl[g] = SET_W'(g % NUM_SETS);
	end

	always_comb begin
		c.opcode = item.opcode;
		c.way    = item.way_index;
		c.tag    = item.tag;
		c.status = item.line_status;
		unique case (item.opcode)
			OP_TOUCH:  keep = 1'b1;
			OP_QUERY:  keep = 1'b1;
			OP_UPDATE: keep = (32'(item.way_index) < NUM_WAYS);
			default:   keep = 1'b0;
		endcase
	end

	lpcv_fifo #(.W(QW), .DEPTH(2)) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push && keep),
		.wdata ({c, mod_tbl[item.set_index]}),
		.full  (full),
		.rd    (cmd_pop),
		.rdata (q_out),
		.empty (cmd_empty)
	);

	assign cmd     = q_out[QW-1:SET_W];
	assign cmd_set = q_out[SET_W-1:0];

endmodule
`default_nettype wire

>>> rtl/lpcv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpcv_back
// Set memory and sequencer: read a set, update or search it, write back.
// ----------------------------------------------------------------------------
module lpcv_back #(
	parameter int NUM_SETS = 256,
	parameter int NUM_WAYS = 8,
	parameter int TAG_BITS = 20,
	parameter int SET_W    = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 policy_mode,
	input  wire logic                 cmd_empty,
	input  wire lpcv_pkg::cmd_t       cmd,
	input  wire logic [SET_W-1:0]     cmd_set,
	output logic                      cmd_pop,
	input  wire logic                 res_full,
	output logic                      res_push,
	output lpcv_pkg::out_item_t       res
);
	import lpcv_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	typedef logic [NUM_WAYS-1:0][31:0]         stamps_t;
	typedef logic [NUM_WAYS-1:0][TAG_BITS-1:0] tags_t;
	typedef logic [NUM_WAYS-1:0][1:0]          states_t;

	stamps_t stamp_mem [NUM_SETS];
	tags_t   tag_mem   [NUM_SETS];
	states_t state_mem [NUM_SETS];
	logic [NUM_SETS-1:0] row_vld_q;

	logic             state_q;
	logic [31:0]      count_q;
	cmd_t             cmd_s1;
	logic [SET_W-1:0] set_s1;
	stamps_t          stamp_s1;
	tags_t            tag_s1;
	states_t          st_s1;
	logic             vld_s1;

	stamps_t     cur_stamp, new_stamp;
	tags_t       cur_tag, new_tag;
	states_t     cur_st, new_st;
	logic [TAG_BITS-1:0] tag_m;
	logic [31:0] count_nx;
	logic        wr_en, exec;
	logic [31:0] best_any, best_cl, best_dt;
	logic [31:0] bs_any, bs_cl, bs_dt;
	logic        f_cl, f_dt;
	out_item_t   r;

	assign exec    = (state_q == ST_EXEC);
	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty && !res_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			row_vld_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (cmd_pop) state_q <= ST_EXEC;
				ST_EXEC: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (exec && cmd_s1.opcode == OP_TOUCH) count_q <= count_nx;
			if (wr_en) row_vld_q[set_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1   <= cmd;
			set_s1   <= cmd_set;
			stamp_s1 <= stamp_mem[cmd_set];
			tag_s1   <= tag_mem[cmd_set];
			st_s1    <= state_mem[cmd_set];
			vld_s1   <= row_vld_q[cmd_set];
		end
		if (wr_en) begin
			stamp_mem[set_s1] <= new_stamp;
			tag_mem[set_s1]   <= new_tag;
			state_mem[set_s1] <= new_st;
		end
	end

	always_comb begin
		cur_stamp = vld_s1 ? stamp_s1 : '0;
		cur_tag   = vld_s1 ? tag_s1 : '0;
		cur_st    = vld_s1 ? st_s1 : '0;
		tag_m     = TAG_BITS'(cmd_s1.tag);
		count_nx  = count_q + 32'd1;
		new_stamp = cur_stamp;
		new_tag   = cur_tag;
		new_st    = cur_st;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (cmd_s1.opcode == OP_TOUCH && cur_tag[w] == tag_m) new_stamp[w] = count_nx;
			if (cmd_s1.opcode == OP_UPDATE && int'(cmd_s1.way) == w) begin
				new_tag[w] = tag_m;
				new_st[w]  = cmd_s1.status;
			end
		end
		wr_en = exec && (cmd_s1.opcode == OP_TOUCH || cmd_s1.opcode == OP_UPDATE);
	end

	always_comb begin
		best_any = '0;
		bs_any   = cur_stamp[0];
		best_cl  = '0;
		bs_cl    = '0;
		f_cl     = 1'b0;
		best_dt  = '0;
		bs_dt    = '0;
		f_dt     = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (cur_stamp[w] < bs_any) begin
				bs_any   = cur_stamp[w];
				best_any = 32'(w);
			end
			if (cur_st[w] == LS_CLEAN && (!f_cl || cur_stamp[w] < bs_cl)) begin
				f_cl    = 1'b1;
				bs_cl   = cur_stamp[w];
				best_cl = 32'(w);
			end
			if (cur_st[w] == LS_DIRTY && (!f_dt || cur_stamp[w] < bs_dt)) begin
				f_dt    = 1'b1;
				bs_dt   = cur_stamp[w];
				best_dt = 32'(w);
			end
		end
		r.victim_clean = 1'b0;
		if (!policy_mode) begin
			r.victim_way = best_any[2:0];
		end else if (f_cl) begin
			r.victim_way   = best_cl[2:0];
			r.victim_clean = 1'b1;
		end else if (f_dt) begin
			r.victim_way = best_dt[2:0];
		end else begin
			r.victim_way = '0;
		end
	end

	assign res_push = exec && (cmd_s1.opcode == OP_QUERY);
	assign res      = r;

endmodule
`default_nettype wire
